// ===== rtl/core/blp_pkg.sv =====
// shared types and constants of the bloom header line parser
`default_nettype none

package blp_pkg;

  // default limit on the number of space separated tokens of a line
  localparam int unsigned BLP_MAX_TOKENS = 16;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_UPA   = "A";
  localparam logic [7:0] CH_UPZ   = "Z";
  localparam logic [7:0] CH_UPB   = "B";
  localparam logic [7:0] CH_UPK   = "K";
  localparam logic [7:0] CH_UPH   = "H";
  localparam logic [7:0] CH_UPI   = "I";

  // fixed words, first character in the top byte
  localparam logic [31:0] WORD_IGET = "IGET";
  localparam logic [31:0] WORD_HSND = "HSND";
  localparam logic [31:0] WORD_BLOM = "blom";

  // limits
  localparam logic [3:0]  FRAME_MIN = 4'd15;
  localparam logic [63:0] COUNT_MAX = 64'd192;
  localparam logic [63:0] BITS_MAX  = 64'd64;
  localparam logic [14:0] PROD_MAX  = 15'd192;

  // kind of the field token being parsed
  typedef enum logic [1:0] {
    FK_OTHER = 2'd0,
    FK_COUNT = 2'd1,
    FK_BITS  = 2'd2
  } field_e;

  // per-line parse state, all zero at reset and after each line
  typedef struct packed {
    logic        reject;
    logic [3:0]  frame_len;
    logic [2:0]  char_pos;
    logic [63:0] num;
    logic        ovf;
    field_e      fkind;
    logic [7:0]  prev;
    logic        cr_pend;
    logic        send;
    logic [7:0]  cnt;
    logic [6:0]  bits;
    logic        cnt_seen;
    logic        bits_seen;
    logic [60:0] size;
  } blp_state_t;

  // one result transaction
  typedef struct packed {
    logic        accepted;
    logic        kind;
    logic [60:0] byte_count;
    logic [7:0]  hash_count;
    logic [6:0]  hash_bits;
    logic        has_count;
    logic        has_bits;
  } blp_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/blp_if.sv =====
// valid/ready channel interfaces for line bytes and header results
`default_nettype none

interface blp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface blp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        kind;
  logic [60:0] byte_count;
  logic [7:0]  hash_count;
  logic [6:0]  hash_bits;
  logic        has_count;
  logic        has_bits;

  modport source (
    output valid, output accepted, output kind, output byte_count,
    output hash_count, output hash_bits, output has_count, output has_bits,
    input ready
  );
  modport sink (
    input valid, input accepted, input kind, input byte_count,
    input hash_count, input hash_bits, input has_count, input has_bits,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bloom_header_line_parser.sv =====
// top level of the bloom header line parser
`default_nettype none

// Checks a header line streamed one byte per transaction and emits one result
// transaction for the byte marked last: whether the line is a valid IGET or
// HSND bloom header, its byte count, and the optional BK and BH values (all
// zero when rejected). A trailing LF, and a CR just before it, are stripped.
// Throughput is one byte per clock cycle; the limit is the per-byte update of
// the parse state, which is done combinationally between the input register
// and the result register. The result register captures a result from its last
// byte in the input register. The input keeps taking bytes while a
// result waits; it stalls only when a further last byte meets an untaken result.

module bloom_header_line_parser import blp_pkg::*; #(
  parameter int unsigned MAX_TOKENS = BLP_MAX_TOKENS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  blp_in_if.sink     in_ch,
  blp_out_if.source  out_ch
);

  localparam int unsigned TokW = $clog2(MAX_TOKENS);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            adv;
  blp_state_t      state_q;
  blp_state_t      state_d;
  logic [TokW-1:0] tok_q;
  logic [TokW-1:0] tok_d;
  blp_result_t     result_d;
  blp_result_t     out_q;
  logic            out_valid_q;

  // a byte moves on unless it would produce a result that has nowhere to go
  assign adv         = in_valid_q && (!in_last_q || !out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || adv;

  blp_step #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_step (
    .state_i  (state_q),
    .tok_i    (tok_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .tok_o    (tok_d),
    .result_o (result_d)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      tok_q       <= '0;
    end else begin
      if (in_ch.ready) in_valid_q <= in_ch.valid;
      if (adv) begin
        state_q <= state_d;
        tok_q   <= tok_d;
      end
      if (adv && in_last_q) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.data_byte;
      in_last_q <= in_ch.last_byte;
    end
    if (adv && in_last_q) out_q <= result_d;
  end

  // result port
  assign out_ch.valid      = out_valid_q;
  assign out_ch.accepted   = out_q.accepted;
  assign out_ch.kind       = out_q.kind;
  assign out_ch.byte_count = out_q.byte_count;
  assign out_ch.hash_count = out_q.hash_count;
  assign out_ch.hash_bits  = out_q.hash_bits;
  assign out_ch.has_count  = out_q.has_count;
  assign out_ch.has_bits   = out_q.has_bits;

`ifndef ASSERT_OFF
  // input stalls only behind a last byte blocked by an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (in_valid_q && in_last_q && out_valid_q && !out_ch.ready))
    else $error("input stalled without a blocked result");

  // a rejected line carries all-zero fields
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.accepted) |->
      (!out_ch.kind && (out_ch.byte_count == 61'd0) && (out_ch.hash_count == 8'd0) &&
       (out_ch.hash_bits == 7'd0) && !out_ch.has_count && !out_ch.has_bits))
    else $error("rejected result with nonzero fields");

  // presence flags agree with the values, which stay within their limits
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |->
      ((out_ch.has_count == (out_ch.hash_count != 8'd0)) &&
       (out_ch.has_bits == (out_ch.hash_bits != 7'd0)) &&
       (out_ch.hash_count <= 8'd192) && (out_ch.hash_bits <= 7'd64) &&
       (out_ch.byte_count[2:0] == 3'd0)))
    else $error("result field out of range");

  // parse state is clean after a line ends
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> ((tok_q == '0) && (state_q.frame_len == 4'd0) && !state_q.reject))
    else $error("parse state not cleared after a line");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/blp_step.sv =====
// per-byte next state and end-of-line verdict of the header parser
`default_nettype none

module blp_step import blp_pkg::*; #(
  parameter int unsigned MAX_TOKENS = BLP_MAX_TOKENS,
  localparam int unsigned TokW = $clog2(MAX_TOKENS)
) (
  input  blp_state_t        state_i,
  input  logic [TokW-1:0]   tok_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output blp_state_t        state_o,
  output logic [TokW-1:0]   tok_o,
  output blp_result_t       result_o
);

  // close the current token and check it against its position
  function automatic blp_state_t end_token(blp_state_t s, logic [TokW-1:0] tok);
    blp_state_t r;
    r = s;
    if (s.char_pos == 3'd0) begin
      r.reject = 1'b1;
    end else if (tok <= TokW'(1)) begin
      if (s.char_pos != 3'd4) r.reject = 1'b1;
    end else if (tok <= TokW'(3)) begin
      if (s.char_pos != 3'd1) r.reject = 1'b1;
    end else if (tok == TokW'(4)) begin
      if (s.ovf || (s.num[63:61] != 3'd0) || (s.num[2:0] != 3'd0)) r.reject = 1'b1;
      else r.size = s.num[60:0];
    end else if (s.char_pos < 3'd3) begin
      r.reject = 1'b1;
    end else if (s.fkind == FK_COUNT) begin
      if (s.cnt_seen || s.ovf || (s.num == 64'd0) || (s.num > COUNT_MAX)) begin
        r.reject = 1'b1;
      end else begin
        r.cnt      = s.num[7:0];
        r.cnt_seen = 1'b1;
      end
    end else if (s.fkind == FK_BITS) begin
      if (s.bits_seen || s.ovf || (s.num == 64'd0) || (s.num > BITS_MAX)) begin
        r.reject = 1'b1;
      end else begin
        r.bits      = s.num[6:0];
        r.bits_seen = 1'b1;
      end
    end
    return r;
  endfunction

  // decimal accumulate with overflow flag
  function automatic blp_state_t add_digit(blp_state_t s, logic [7:0] c);
    blp_state_t  r;
    logic [67:0] sum;
    r   = s;
    sum = 68'({s.num, 3'b000}) + 68'({s.num, 1'b0}) + 68'(c[3:0]);
    if ((c < CH_ZERO) || (c > CH_NINE)) begin
      r.reject = 1'b1;
    end else if (!s.ovf) begin
      if (sum[67:64] != 4'd0) r.ovf = 1'b1;
      else r.num = sum[63:0];
    end
    return r;
  endfunction

  // character of a four letter word at a token position
  function automatic logic word_ok(logic [31:0] w, logic [2:0] pos, logic [7:0] c);
    logic [7:0] ch;
    case (pos[1:0])
      2'd0:    ch = w[31:24];
      2'd1:    ch = w[23:16];
      2'd2:    ch = w[15:8];
      default: ch = w[7:0];
    endcase
    return (pos < 3'd4) && (ch == c);
  endfunction

  blp_state_t      s;
  blp_state_t      e;
  logic [TokW-1:0] tok;
  logic [2:0]      pos;
  logic            is_lf;
  logic            is_cr;
  logic            is_upper;
  logic            is_digit;
  logic            ok;
  logic [14:0]     prod;
  logic [63:0]     size_shift;

  always_comb begin
    s        = state_i;
    tok      = tok_i;
    pos      = state_i.char_pos;
    is_lf    = (byte_i == CH_LF);
    is_cr    = (byte_i == CH_CR);
    is_upper = (byte_i >= CH_UPA) && (byte_i <= CH_UPZ);
    is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

    // a held cr must be followed by the final lf
    if (s.cr_pend) begin
      s.cr_pend = 1'b0;
      if (!(is_lf && last_i)) s.reject = 1'b1;
    end

    if (last_i && is_lf) begin
      // trailing lf is stripped
    end else if (is_cr && !last_i) begin
      s.cr_pend = 1'b1;
    end else begin
      // byte joins the frame
      if (s.frame_len != FRAME_MIN) s.frame_len = s.frame_len + 4'd1;
      if ((byte_i < CH_SP) || (byte_i > CH_TILDE)) begin
        s.reject = 1'b1;
        s.prev   = byte_i;
      end else if (byte_i == CH_SP) begin
        s = end_token(s, tok);
        if (tok == TokW'(MAX_TOKENS - 1)) s.reject = 1'b1;
        else tok = tok + TokW'(1);
        s.char_pos = 3'd0;
        s.num      = 64'd0;
        s.ovf      = 1'b0;
        s.fkind    = FK_OTHER;
        s.prev     = byte_i;
      end else begin
        // token content check by position
        if (tok == TokW'(0)) begin
          if (pos == 3'd0) begin
            if (byte_i == CH_UPI) s.send = 1'b0;
            else if (byte_i == CH_UPH) s.send = 1'b1;
            else s.reject = 1'b1;
          end else if (!word_ok(s.send ? WORD_HSND : WORD_IGET, pos, byte_i)) begin
            s.reject = 1'b1;
          end
        end else if (tok == TokW'(1)) begin
          if (!word_ok(WORD_BLOM, pos, byte_i)) s.reject = 1'b1;
        end else if (tok == TokW'(2)) begin
          if ((pos != 3'd0) || (byte_i != CH_SLASH)) s.reject = 1'b1;
        end else if (tok == TokW'(3)) begin
          if ((pos != 3'd0) || (byte_i != CH_ZERO)) s.reject = 1'b1;
        end else if (tok == TokW'(4)) begin
          s = add_digit(s, byte_i);
        end else if (pos == 3'd0) begin
          if (!is_upper) s.reject = 1'b1;
        end else if (pos == 3'd1) begin
          if (!(is_upper || is_digit)) s.reject = 1'b1;
          if ((s.prev == CH_UPB) && (byte_i == CH_UPK)) s.fkind = FK_COUNT;
          else if ((s.prev == CH_UPB) && (byte_i == CH_UPH)) s.fkind = FK_BITS;
          else s.fkind = FK_OTHER;
        end else if (s.fkind != FK_OTHER) begin
          s = add_digit(s, byte_i);
        end
        if (s.char_pos != 3'd7) s.char_pos = s.char_pos + 3'd1;
        s.prev = byte_i;
      end
    end

    // end-of-line checks
    e          = end_token(s, tok);
    prod       = 15'(e.cnt) * 15'(e.bits);
    size_shift = {e.size, 3'b000} >> e.bits;
    ok         = !e.reject && (e.frame_len == FRAME_MIN) && (tok >= TokW'(4));
    if (!e.send && !(e.cnt_seen && e.bits_seen)) ok = 1'b0;
    if (e.cnt_seen && e.bits_seen && (prod > PROD_MAX)) ok = 1'b0;
    if (e.bits_seen && (e.bits < 7'd64) && (size_shift != 64'd0)) ok = 1'b0;

    result_o.accepted   = ok;
    result_o.kind       = ok & e.send;
    result_o.byte_count = ok ? e.size : 61'd0;
    result_o.hash_count = (ok && e.cnt_seen) ? e.cnt : 8'd0;
    result_o.hash_bits  = (ok && e.bits_seen) ? e.bits : 7'd0;
    result_o.has_count  = ok & e.cnt_seen;
    result_o.has_bits   = ok & e.bits_seen;

    // a finished line leaves clean state for the next one
    if (last_i) begin
      state_o = '0;
      tok_o   = '0;
    end else begin
      state_o = s;
      tok_o   = tok;
    end
  end

endmodule

`default_nettype wire

// ===== test/bloom_header_line_checker.sv =====
// scoreboard for the bloom header line parser: per-byte line predictor and result comparison
`timescale 1ns / 1ps

module bloom_header_line_checker import blp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  blp_in_if    in_ch,
  blp_out_if   out_ch,
  output int   mismatch_count_o,
  output int   results_pending_o
);

  // predicted parse state of the line in flight
  logic        ln_reject;
  logic [3:0]  ln_frame_len;
  int unsigned ln_token;
  logic [2:0]  ln_char_pos;
  logic [63:0] ln_num;
  logic        ln_ovf;
  field_e      ln_fkind;
  logic [7:0]  ln_prev;
  logic        ln_cr_pend;
  logic        ln_send;
  logic [7:0]  ln_cnt;
  logic [6:0]  ln_bits;
  logic        ln_cnt_seen;
  logic        ln_bits_seen;
  logic [63:0] ln_size;

  // verdicts still owed by the block, oldest first
  blp_result_t expected_verdicts[$];
  blp_result_t predicted;
  blp_result_t observed;

  function automatic void line_clear();
    ln_reject    = 1'b0;
    ln_frame_len = '0;
    ln_token     = 0;
    ln_char_pos  = '0;
    ln_num       = '0;
    ln_ovf       = 1'b0;
    ln_fkind     = FK_OTHER;
    ln_prev      = '0;
    ln_cr_pend   = 1'b0;
    ln_send      = 1'b0;
    ln_cnt       = '0;
    ln_bits      = '0;
    ln_cnt_seen  = 1'b0;
    ln_bits_seen = 1'b0;
    ln_size      = '0;
  endfunction

  // decimal accumulation, overflow sticks until the token ends
  function automatic void take_digit(logic [7:0] c);
    logic [63:0] d;
    if (c < CH_ZERO || c > CH_NINE) begin
      ln_reject = 1'b1;
      return;
    end
    d = 64'(c - CH_ZERO);
    if (ln_ovf) return;
    if (ln_num > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) ln_ovf = 1'b1;
    else ln_num = ln_num * 64'd10 + d;
  endfunction

  function automatic void match_word(logic [31:0] w, int unsigned pos, logic [7:0] c);
    if (pos >= 4 || w[31 - 8 * pos -: 8] != c) ln_reject = 1'b1;
  endfunction

  // checks of a finished token, depending on its place in the line
  function automatic void close_token();
    if (ln_char_pos == 0) begin
      ln_reject = 1'b1;
      return;
    end
    if (ln_token <= 1) begin
      if (ln_char_pos != 4) ln_reject = 1'b1;
    end else if (ln_token <= 3) begin
      if (ln_char_pos != 1) ln_reject = 1'b1;
    end else if (ln_token == 4) begin
      // byte count must fit 61 bits and be a multiple of 8
      if (ln_ovf || ln_num > 64'h1FFF_FFFF_FFFF_FFFF || ln_num[2:0] != 3'd0) ln_reject = 1'b1;
      else ln_size = ln_num;
    end else begin
      if (ln_char_pos < 3) begin
        ln_reject = 1'b1;
      end else if (ln_fkind == FK_COUNT) begin
        if (ln_cnt_seen || ln_ovf || ln_num == 0 || ln_num > COUNT_MAX) ln_reject = 1'b1;
        else begin
          ln_cnt      = ln_num[7:0];
          ln_cnt_seen = 1'b1;
        end
      end else if (ln_fkind == FK_BITS) begin
        if (ln_bits_seen || ln_ovf || ln_num == 0 || ln_num > BITS_MAX) ln_reject = 1'b1;
        else begin
          ln_bits      = ln_num[6:0];
          ln_bits_seen = 1'b1;
        end
      end
    end
  endfunction

  // one byte of the frame
  function automatic void take_char(logic [7:0] c);
    logic [2:0] pos;
    pos = ln_char_pos;
    if (ln_frame_len < FRAME_MIN) ln_frame_len = ln_frame_len + 4'd1;
    if (c < CH_SP || c > CH_TILDE) begin
      ln_reject = 1'b1;
      ln_prev   = c;
      return;
    end
    if (c == CH_SP) begin
      close_token();
      if (ln_token + 1 >= BLP_MAX_TOKENS) ln_reject = 1'b1;
      else ln_token = ln_token + 1;
      ln_char_pos = '0;
      ln_num      = '0;
      ln_ovf      = 1'b0;
      ln_fkind    = FK_OTHER;
      ln_prev     = c;
      return;
    end
    if (ln_token == 0) begin
      if (pos == 0) begin
        if (c == CH_UPI) ln_send = 1'b0;
        else if (c == CH_UPH) ln_send = 1'b1;
        else ln_reject = 1'b1;
      end else begin
        match_word(ln_send ? WORD_HSND : WORD_IGET, pos, c);
      end
    end else if (ln_token == 1) begin
      match_word(WORD_BLOM, pos, c);
    end else if (ln_token == 2) begin
      if (pos != 0 || c != CH_SLASH) ln_reject = 1'b1;
    end else if (ln_token == 3) begin
      if (pos != 0 || c != CH_ZERO) ln_reject = 1'b1;
    end else if (ln_token == 4) begin
      take_digit(c);
    end else begin
      // field token: letter, letter or digit, then digits for BK and BH
      if (pos == 0) begin
        if (c < CH_UPA || c > CH_UPZ) ln_reject = 1'b1;
      end else if (pos == 1) begin
        if (!((c >= CH_UPA && c <= CH_UPZ) || (c >= CH_ZERO && c <= CH_NINE))) ln_reject = 1'b1;
        if (ln_prev == CH_UPB && c == CH_UPK) ln_fkind = FK_COUNT;
        else if (ln_prev == CH_UPB && c == CH_UPH) ln_fkind = FK_BITS;
        else ln_fkind = FK_OTHER;
      end else if (ln_fkind != FK_OTHER) begin
        take_digit(c);
      end
    end
    if (ln_char_pos < 3'd7) ln_char_pos = ln_char_pos + 3'd1;
    ln_prev = c;
  endfunction

  // final checks and the verdict of the line
  function automatic void finish_line(output blp_result_t r);
    logic ok;
    close_token();
    ok = !ln_reject;
    if (ln_frame_len < FRAME_MIN || ln_token < 4) ok = 1'b0;
    if (ok && !ln_send && (!ln_cnt_seen || !ln_bits_seen)) ok = 1'b0;
    if (ok && ln_cnt_seen && ln_bits_seen && 15'(ln_cnt) * 15'(ln_bits) > PROD_MAX) ok = 1'b0;
    if (ok && ln_bits_seen && ln_bits < 7'd64 && (ln_size << 3) >= (64'd1 << ln_bits)) ok = 1'b0;
    r = '0;
    if (ok) begin
      r.accepted   = 1'b1;
      r.kind       = ln_send;
      r.byte_count = ln_size[60:0];
      r.hash_count = ln_cnt_seen ? ln_cnt : 8'd0;
      r.hash_bits  = ln_bits_seen ? ln_bits : 7'd0;
      r.has_count  = ln_cnt_seen;
      r.has_bits   = ln_bits_seen;
    end
    line_clear();
  endfunction

  // line ending handling: one LF stripped, CR just before it stripped too
  function automatic bit line_step(logic [7:0] b, logic last, output blp_result_t r);
    r = '0;
    if (ln_cr_pend) begin
      ln_cr_pend = 1'b0;
      if (b == CH_LF && last) begin
        finish_line(r);
        return 1'b1;
      end
      ln_reject = 1'b1;
    end
    if (last && b == CH_LF) begin
      finish_line(r);
      return 1'b1;
    end
    if (b == CH_CR && !last) begin
      ln_cr_pend = 1'b1;
      return 1'b0;
    end
    take_char(b);
    if (last) begin
      finish_line(r);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // watch both channels, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_clear();
      expected_verdicts.delete();
      mismatch_count_o  = 0;
      results_pending_o = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (line_step(in_ch.data_byte, in_ch.last_byte, predicted))
          expected_verdicts.insert(expected_verdicts.size(), predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        observed.accepted   = out_ch.accepted;
        observed.kind       = out_ch.kind;
        observed.byte_count = out_ch.byte_count;
        observed.hash_count = out_ch.hash_count;
        observed.hash_bits  = out_ch.hash_bits;
        observed.has_count  = out_ch.has_count;
        observed.has_bits   = out_ch.has_bits;
        if (expected_verdicts.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected result transaction acc=%0b kind=%0b count=%0d",
                     $realtime, observed.accepted, observed.kind, observed.byte_count);
          mismatch_count_o++;
        end else begin
          predicted = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (observed.accepted !== predicted.accepted || observed.kind !== predicted.kind ||
              observed.byte_count !== predicted.byte_count ||
              observed.hash_count !== predicted.hash_count ||
              observed.hash_bits !== predicted.hash_bits ||
              observed.has_count !== predicted.has_count ||
              observed.has_bits !== predicted.has_bits) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: mismatch expected acc=%0b kind=%0b count=%0d bk=%0d bh=%0d hk=%0b hh=%0b",
                       $realtime, predicted.accepted, predicted.kind, predicted.byte_count,
                       predicted.hash_count, predicted.hash_bits, predicted.has_count,
                       predicted.has_bits);
              $display("%0t:          got acc=%0b kind=%0b count=%0d bk=%0d bh=%0d hk=%0b hh=%0b",
                       $realtime, observed.accepted, observed.kind, observed.byte_count,
                       observed.hash_count, observed.hash_bits, observed.has_count,
                       observed.has_bits);
            end
            mismatch_count_o++;
          end
        end
      end
      results_pending_o = expected_verdicts.size();
    end
  end

endmodule

// ===== test/bloom_header_line_parser_test.sv =====
// top of the bloom header line parser testbench: clock, reset, line stimulus and verdict
`timescale 1ns / 1ps

module bloom_header_line_parser_test import blp_pkg::*; ();

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  blp_in_if  in_ch();
  blp_out_if out_ch();

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;

  // bytes of the line being built
  logic [7:0] line_q[$];
  int         burst_left;
  int         bytes_sent;
  bit         hold_req;

  // hand-picked lines: extremes, cross checks and malformed endings
  string directed_lines[] = '{
    "IGET blom / 0 8 BK3 BH8\012",
    "HSND blom / 0 8\015\012",
    "HSND blom / 0 0",
    "HSND blom / 0 2305843009213693944 BK192\012",
    "IGET blom / 0 2305843009213693944 BH64 BK3\015\012",
    "IGET blom / 0 0 BK1 BH1\012",
    "IGET blom / 0 8 BK1 BH1\012",
    "HSND blom / 0 18446744073709551616\012",
    "HSND blom / 0 18446744073709551608\012",
    "HSND blom / 0 12\012",
    "HSND blom / 0 8 BK193 BH65\012",
    "HSND blom / 0 8 BK0\012",
    "HSND blom / 0 8 BK2 BK2\012",
    "IGET blom / 0 0 BK4 BH64\012",
    "IGET blom / 0 0 BK3\012",
    "HSND blom / 0 0008 XY9 ABCDEFGHIJ BKZ\012",
    "HSND blom / 0 8 XY9 ABCDEFGHIJ\012",
    "HSND blom / 0 8 ab1 AB\012",
    "HSND blom /\015 0 8\012",
    "HSND blom / 0 8\015",
    "HSND blom / 0\012 8\012",
    "\012",
    " HSND blom /  0 8 \012",
    "HSND blom / 0 8 AAA BBB CCC DDD EEE FFF GGG HHH III JJJ KKK\012",
    "HSND blom / 0 8 AAA BBB CCC DDD EEE FFF GGG HHH III JJJ KKK LLL\012",
    "HSND blom / 0 8 X\377Z\200\012"
  };

  bloom_header_line_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bloom_header_line_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bloom_header_line_parser] ERROR");
      $finish;
    end
  end

  // receiver: ready pattern changes every window, one long hold when requested
  initial begin
    int hold_left;
    int ready_pct;
    int tick;
    bit hold_done;
    out_ch.ready = 1'b0;
    hold_left = 0;
    ready_pct = 100;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (tick % 97 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.insert(line_q.size(), s[i]);
  endfunction

  function automatic logic [7:0] upper_or_digit();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(CH_UPA, CH_UPZ));
    return 8'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  // BK or BH token, in range half of the time, else zero, too large or malformed
  function automatic string field_text(string code, int unsigned good, int unsigned beyond);
    case ($urandom_range(0, 11))
      0: return {code, "0"};
      1: return $sformatf("%s%0d", code, beyond);
      2: return $sformatf("%s%0d", code, $urandom_range(beyond, 99999));
      3: return $sformatf("%s%c1", code, upper_or_digit());
      4: return code;
      5: return $sformatf("%s99999999999999999999", code);
      default: return $sformatf("%s%0d", code, good);
    endcase
  endfunction

  // other field code: letter, then letters or digits
  function automatic string other_field();
    string t;
    int unsigned len;
    len = $urandom_range(3, 9);
    t = $sformatf("%c", 8'($urandom_range(CH_UPA, CH_UPZ)));
    for (int i = 1; i < len; i++) t = $sformatf("%s%c", t, upper_or_digit());
    if ($urandom_range(0, 15) == 0) t = t.substr(0, 1);
    if ($urandom_range(0, 15) == 0) t[0] = 8'($urandom_range("a", "z"));
    return t;
  endfunction

  // well-formed header with random content, mostly consistent
  function automatic void compose_header();
    string       flds[$];
    logic [63:0] size_v;
    int unsigned bits_n;
    int unsigned cnt_n;
    int unsigned extras;
    bit          is_send;
    is_send = $urandom_range(0, 1);
    bits_n  = $urandom_range(1, 64);
    cnt_n   = $urandom_range(1, 192 / bits_n);
    case ($urandom_range(0, 9))
      0: size_v = '0;
      1: size_v = 64'h1FFF_FFFF_FFFF_FFF8;
      2: size_v = {$urandom, $urandom};
      3: size_v = {$urandom, $urandom} & ~64'd7;
      default: size_v = (bits_n > 3) ?
                        ({$urandom, $urandom} & ((64'd1 << (bits_n - 3)) - 1) & ~64'd7) : '0;
    endcase
    if (is_send) put_text("HSND");
    else put_text("IGET");
    put_text(" blom / 0 ");
    if ($urandom_range(0, 19) == 0) put_text("18446744073709551616");
    else begin
      if ($urandom_range(0, 9) == 0) put_text("00");
      put_text($sformatf("%0d", size_v));
    end
    if ($urandom_range(0, 9) < (is_send ? 5 : 9))
      flds.insert($urandom_range(0, flds.size()), field_text("BK", cnt_n, 193));
    if ($urandom_range(0, 9) < (is_send ? 5 : 9))
      flds.insert($urandom_range(0, flds.size()), field_text("BH", bits_n, 65));
    if ($urandom_range(0, 19) == 0 && flds.size() > 0)
      flds.insert($urandom_range(0, flds.size()), flds[0]);
    extras = $urandom_range(0, 3);
    for (int i = 0; i < extras; i++)
      flds.insert($urandom_range(0, flds.size()), other_field());
    foreach (flds[i]) put_text({" ", flds[i]});
  endfunction

  // random line: noise, a clean header, or a header with one defect
  function automatic void make_random_line();
    int unsigned sel;
    int unsigned pos;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) line_q.insert(line_q.size(), 8'($urandom));
      return;
    end
    compose_header();
    if (sel >= 75) begin
      pos = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 6))
        0: line_q[pos] = 8'($urandom);
        1: line_q[pos] = CH_SP;
        2: line_q.push_front(CH_SP);
        3: line_q.insert(line_q.size(), CH_SP);
        4: line_q.insert(pos, CH_LF);
        5: line_q.insert(pos, CH_CR);
        default: begin
          n = $urandom_range(1, line_q.size() - 1);
          while (line_q.size() > n) void'(line_q.pop_back());
        end
      endcase
    end
    // line ending
    case ($urandom_range(0, 9))
      6, 7: begin
        line_q.insert(line_q.size(), CH_CR);
        line_q.insert(line_q.size(), CH_LF);
      end
      8: ;
      9: begin
        line_q.insert(line_q.size(), CH_CR);
        if ($urandom_range(0, 1) != 0) line_q.insert(line_q.size(), 8'($urandom));
      end
      default: line_q.insert(line_q.size(), CH_LF);
    endcase
  endfunction

  // one byte transaction, sent in bursts with random gaps
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // stimulus and verdict
  initial begin
    int line_no;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    burst_left      = 0;
    bytes_sent      = 0;
    hold_req        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_lines[i]) begin
      put_text(directed_lines[i]);
      send_line();
    end
    line_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      // stall the result side for a long stretch while lines keep coming
      if (line_no == 5) hold_req = 1'b1;
      make_random_line();
      send_line();
      line_no++;
    end
    in_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[bloom_header_line_parser] OK");
    end else begin
      $display("[bloom_header_line_parser] ERROR");
    end
    $finish;
  end

endmodule
